// ===== hw/rtl/heq_pkg.sv =====
`timescale 1ns / 1ps
package heq_pkg;

    localparam int unsigned MAX_PIXELS  = 4194304;
    localparam int unsigned GRAY_LEVELS = 256;
    localparam int unsigned LEVEL_TOP   = GRAY_LEVELS - 1;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned LVL_W = $clog2(GRAY_LEVELS);
    localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int unsigned DEN_W = CNT_W + 1;
    localparam int unsigned Q_W   = $clog2(GRAY_LEVELS);

    localparam longint unsigned NUM_MAX =
        longint'(2) * longint'(LEVEL_TOP) * longint'(MAX_PIXELS) + longint'(MAX_PIXELS);
    localparam int unsigned NUM_W = $clog2(NUM_MAX + 1);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    localparam logic FUNC_COUNT = 1'b0;
    localparam logic FUNC_MAP   = 1'b1;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel;
        logic             first;
        logic             last;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] mapped_pixel;
        logic             overflow;
    } t_out_word;

    typedef struct packed {
        logic             is_map;
        logic [LVL_W-1:0] lvl;
        logic             first;
        logic             last;
    } t_cmd;

    function automatic logic [LVL_W-1:0] level_of(input logic [PIX_W-1:0] pix);
        logic [LVL_W-1:0] lvl;
        if (32'(pix) > LEVEL_TOP) begin
            lvl = LVL_W'(LEVEL_TOP);
        end else begin
            lvl = LVL_W'(pix);
        end
        return lvl;
    endfunction

endpackage

// ===== hw/rtl/heq_div.sv =====
`timescale 1ns / 1ps
module heq_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [heq_pkg::NUM_W-1:0]   i_num,
    input  logic [heq_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [heq_pkg::Q_W-1:0]     o_quot
);

    localparam int unsigned SH_W   = heq_pkg::DEN_W + heq_pkg::Q_W - 1;
    localparam int unsigned CMP_W  = (heq_pkg::NUM_W > SH_W) ? heq_pkg::NUM_W : SH_W;
    localparam int unsigned STEP_W = $clog2(heq_pkg::Q_W);

    logic                    r_busy;
    logic [STEP_W-1:0]       r_step;
    logic [CMP_W-1:0]        r_rem;
    logic [CMP_W-1:0]        r_dsh;
    logic [heq_pkg::Q_W-1:0] r_quot;

    logic                    ge;
    logic [CMP_W-1:0]        rem_sub;
    logic [heq_pkg::Q_W-1:0] quot_nx;

    always_comb begin
        ge      = r_rem >= r_dsh;
        rem_sub = r_rem - r_dsh;
        quot_nx = {r_quot[heq_pkg::Q_W-2:0], ge};
    end

    assign o_done = r_busy && (r_step == '0);
    assign o_quot = quot_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_step == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= STEP_W'(heq_pkg::Q_W - 1);
            r_rem  <= CMP_W'(i_num);
            r_dsh  <= CMP_W'(i_den) << (heq_pkg::Q_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= rem_sub;
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= quot_nx;
            r_step <= r_step - STEP_W'(1);
        end
    end

endmodule

// ===== hw/rtl/heq_front.sv =====
`timescale 1ns / 1ps
module heq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  heq_pkg::t_in_word   i_in_word,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop,
    output heq_pkg::t_cmd       o_cmd
);

    heq_pkg::t_cmd                r_mem [heq_pkg::QDEPTH];
    logic [heq_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [heq_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [heq_pkg::QPTR_W:0]     r_count;

    heq_pkg::t_cmd                cmd_in;
    logic                         push;

    always_comb begin
        cmd_in.is_map = (i_in_word.func == heq_pkg::FUNC_MAP);
        cmd_in.lvl    = heq_pkg::level_of(i_in_word.pixel);
        cmd_in.first  = !cmd_in.is_map && i_in_word.first;
        cmd_in.last   = !cmd_in.is_map && i_in_word.last;
    end

    assign o_in_ready  = (r_count != (heq_pkg::QPTR_W + 1)'(heq_pkg::QDEPTH));
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + heq_pkg::QPTR_W'(1);
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + heq_pkg::QPTR_W'(1);
            end
            if (push && !i_cmd_pop) begin
                r_count <= r_count + (heq_pkg::QPTR_W + 1)'(1);
            end else if (!push && i_cmd_pop) begin
                r_count <= r_count - (heq_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/heq_back.sv =====
`timescale 1ns / 1ps
module heq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  heq_pkg::t_cmd       i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output heq_pkg::t_out_word  o_out_word
);

    localparam logic [2:0] ST_RUN = 3'd0;
    localparam logic [2:0] ST_RD  = 3'd1;
    localparam logic [2:0] ST_ACC = 3'd2;
    localparam logic [2:0] ST_MUL = 3'd3;
    localparam logic [2:0] ST_DIV = 3'd4;

    logic [heq_pkg::CNT_W-1:0]       r_hist [heq_pkg::GRAY_LEVELS];
    logic [heq_pkg::CNT_W-1:0]       r_hist_rd;
    logic [heq_pkg::Q_W-1:0]         r_map [heq_pkg::GRAY_LEVELS];
    logic [heq_pkg::Q_W-1:0]         r_map_rd;

    logic [2:0]                      r_state, n_state;
    logic                            r_s_vld, n_s_vld;
    heq_pkg::t_cmd                   r_s, n_s;
    logic [heq_pkg::GRAY_LEVELS-1:0] r_hvld, n_hvld;
    logic [heq_pkg::CNT_W-1:0]       r_total, n_total;
    logic                            r_ovf, n_ovf;
    logic                            r_wr_vld, n_wr_vld;
    logic [heq_pkg::LVL_W-1:0]       r_wr_addr, n_wr_addr;
    logic [heq_pkg::CNT_W-1:0]       r_wr_data, n_wr_data;
    logic                            r_map_ok, n_map_ok;
    logic [heq_pkg::LVL_W-1:0]       r_g, n_g;
    logic [heq_pkg::CNT_W-1:0]       r_cdf, n_cdf;
    logic                            r_out_vld, n_out_vld;
    heq_pkg::t_out_word              r_out, n_out;

    logic                            out_free;
    logic                            s_cnt;
    logic                            s_map;
    logic                            s_done;
    logic [heq_pkg::CNT_W-1:0]       bin_old;
    logic [heq_pkg::CNT_W-1:0]       bin_rd;
    logic [heq_pkg::CNT_W-1:0]       cur_total;
    logic                            cnt_ok;
    logic                            hist_we;
    logic [heq_pkg::CNT_W-1:0]       hist_wdata;
    logic                            hist_re;
    logic [heq_pkg::LVL_W-1:0]       hist_raddr;
    logic                            map_we;
    logic [heq_pkg::Q_W-1:0]         map_wdata;
    logic                            div_start;
    logic                            div_done;
    logic [heq_pkg::Q_W-1:0]         div_quot;
    logic [heq_pkg::NUM_W-1:0]       div_num;
    logic [heq_pkg::DEN_W-1:0]       div_den;

    heq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign div_num = heq_pkg::NUM_W'(r_cdf) * heq_pkg::NUM_W'(2 * heq_pkg::LEVEL_TOP)
                   + heq_pkg::NUM_W'(r_total);
    assign div_den = {r_total, 1'b0};

    always_comb begin
        out_free  = !r_out_vld || i_out_ready;
        s_cnt     = r_s_vld && !r_s.is_map;
        s_map     = r_s_vld && r_s.is_map;
        s_done    = s_cnt || (s_map && out_free);
        o_cmd_pop = i_cmd_valid && (r_state == ST_RUN) && (!r_s_vld || s_done)
                  && !(s_cnt && r_s.last);

        if (r_s.first) begin
            bin_old = '0;
        end else if (r_wr_vld && (r_wr_addr == r_s.lvl)) begin
            bin_old = r_wr_data;
        end else if (r_hvld[r_s.lvl]) begin
            bin_old = r_hist_rd;
        end else begin
            bin_old = '0;
        end
        bin_rd     = r_hvld[r_g] ? r_hist_rd : '0;
        cur_total  = r_s.first ? '0 : r_total;
        cnt_ok     = (cur_total != heq_pkg::CNT_W'(heq_pkg::MAX_PIXELS));
        hist_we    = s_cnt && cnt_ok;
        hist_wdata = bin_old + heq_pkg::CNT_W'(1);
        hist_re    = o_cmd_pop || (r_state == ST_RD);
        hist_raddr = (r_state == ST_RD) ? r_g : i_cmd.lvl;
        map_wdata  = (r_total == '0) ? '0 : div_quot;

        n_state   = r_state;
        n_s_vld   = r_s_vld;
        n_s       = r_s;
        n_hvld    = r_hvld;
        n_total   = r_total;
        n_ovf     = r_ovf;
        n_wr_vld  = hist_we;
        n_wr_addr = r_s.lvl;
        n_wr_data = hist_wdata;
        n_map_ok  = r_map_ok;
        n_g       = r_g;
        n_cdf     = r_cdf;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        div_start = 1'b0;
        map_we    = 1'b0;

        if (o_cmd_pop) begin
            n_s_vld = 1'b1;
            n_s     = i_cmd;
        end else if (s_done) begin
            n_s_vld = 1'b0;
        end

        if (s_cnt) begin
            if (r_s.first) begin
                n_hvld = '0;
                n_ovf  = 1'b0;
            end
            if (cnt_ok) begin
                n_hvld[r_s.lvl] = 1'b1;
                n_total         = cur_total + heq_pkg::CNT_W'(1);
            end else begin
                n_total = cur_total;
                n_ovf   = 1'b1;
            end
        end

        if (s_map && out_free) begin
            n_out_vld          = 1'b1;
            n_out.mapped_pixel = r_map_ok ? r_map_rd : '0;
            n_out.overflow     = r_ovf;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_RUN: begin
                if (s_cnt && r_s.last) begin
                    n_state = ST_RD;
                    n_g     = '0;
                    n_cdf   = '0;
                end
            end
            ST_RD: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_cdf   = r_cdf + bin_rd;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    map_we = 1'b1;
                    if (r_g == heq_pkg::LVL_W'(heq_pkg::LEVEL_TOP)) begin
                        n_state  = ST_RUN;
                        n_map_ok = 1'b1;
                    end else begin
                        n_g     = r_g + heq_pkg::LVL_W'(1);
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[r_s.lvl] <= hist_wdata;
        end
        if (hist_re) begin
            r_hist_rd <= r_hist[hist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[r_g] <= map_wdata;
        end
        if (o_cmd_pop) begin
            r_map_rd <= r_map[i_cmd.lvl];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_s_vld   <= 1'b0;
            r_hvld    <= '0;
            r_total   <= '0;
            r_ovf     <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_map_ok  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s_vld   <= n_s_vld;
            r_hvld    <= n_hvld;
            r_total   <= n_total;
            r_ovf     <= n_ovf;
            r_wr_vld  <= n_wr_vld;
            r_map_ok  <= n_map_ok;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s       <= n_s;
        r_wr_addr <= n_wr_addr;
        r_wr_data <= n_wr_data;
        r_g       <= n_g;
        r_cdf     <= n_cdf;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

// ===== hw/rtl/histogram_equalization_unit.sv =====
`timescale 1ns / 1ps
// Histogram equalization of 8-bit gray pixels with a 256-bin histogram.
// Input words (i_in_valid / o_in_ready) carry func, pixel, first and last.
// A count word adds its pixel to the histogram; first restarts the image and
// last starts the build of the 256-entry map table. A map word returns one
// output word (o_out_valid / i_out_ready) with the mapped pixel and the
// sticky overflow flag. Count words produce no output.
// Input words enter a four-word queue, so the block takes one word per cycle
// until the queue fills. The back end retires one count or map word per
// cycle while it is not building the table and the output is not stalled,
// and a map word passes through the queue, the command register and the
// output register. The table build walks the 256 entries in turn through
// read, accumulate, multiply and divide states, paced by the 8-step quotient
// unit; input words queue meanwhile and are held off once the queue is full.
// When the receiver stalls, the result waits in the output register; one
// more map word can wait behind it, and the queue then fills and deasserts
// o_in_ready. Reset empties the queue, clears the histogram, the pixel total
// and the overflow flag, and makes the map table read as zero until built.
module histogram_equalization_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  heq_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output heq_pkg::t_out_word  o_out_word
);

    logic          cmd_valid;
    logic          cmd_pop;
    heq_pkg::t_cmd cmd;

    heq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    heq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
